// ----- rtl/bia_pkg.sv -----
`default_nettype none

package bia_pkg;

   typedef enum logic [1:0] {
      CMD_ALLOC = 2'd0,
      CMD_FREE  = 2'd1,
      CMD_ANY   = 2'd2,
      CMD_QUERY = 2'd3
   } command_type;

   typedef enum logic [1:0] {
      STAT_OK      = 2'd0,
      STAT_REFUSED = 2'd1,
      STAT_RANGE   = 2'd2,
      STAT_FULL    = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_DIV,
      S_READ,
      S_MODIFY,
      S_SCAN,
      S_AREAD,
      S_AFIND,
      S_AGRANT
   } state_type;

   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] REG_ID_BASE  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_ID_LIMIT = 2'd1;

   localparam logic [31:0] ID_BASE_RESET  = 32'd0;
   localparam logic [31:0] ID_LIMIT_RESET = 32'd4096;

endpackage

`default_nettype wire

// ----- rtl/bia_ram.sv -----
`default_nettype none

module bia_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic                                     rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- rtl/bia_ffs.sv -----
`default_nettype none

module bia_ffs #(
   parameter int WIDTH = 64
) (
   input  logic [WIDTH-1:0]                         vec,
   output logic [(WIDTH > 1 ? $clog2(WIDTH) : 1)-1:0] idx,
   output logic                                     found
);

   localparam int IDX_W = (WIDTH > 1) ? $clog2(WIDTH) : 1;

   logic [WIDTH-1:0] lowest;

   // isolate the lowest set bit, then encode it
   always_comb begin
      lowest = vec & (~vec + WIDTH'(1));
      idx    = '0;
      for (int i = 0; i < WIDTH; i++) begin
         if (lowest[i]) begin
            idx = idx | IDX_W'(i);
         end
      end
      found = |vec;
   end

endmodule

`default_nettype wire

// ----- rtl/bitmap_id_allocator.sv -----
`default_nettype none

// First-fit id allocator over a bitmap of MAP_WORDS words of WORD_BITS bits held in one
// synchronous RAM, with a flip-flop vector of full words that steers allocate-any straight to
// the first word with a free bit. Requests are handled one at a time. Allocate, free and query
// go through S_DIV, S_READ and S_MODIFY: the offset is split into word and bit by a constant
// reciprocal multiply and a remainder step, then the word goes through one read-modify-write
// on the RAM port. Allocate-any goes through S_SCAN, S_AREAD, S_AFIND and S_AGRANT: full-word
// search, RAM read, free-bit search in the word, then window check and write back. The result
// register lets the next request in while a result waits. After reset a clearing pass writes
// zeros to every word, and req_stall stays high until it ends; csr writes are always taken.
module bitmap_id_allocator
   import bia_pkg::*;
#(
   parameter int MAP_WORDS = 64,
   parameter int WORD_BITS = 64
) (
   input  logic                   clock,
   input  logic                   reset,

   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [1:0]             req_command,
   input  logic [31:0]            req_id,

   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [1:0]             rsp_status,
   output logic [31:0]            rsp_granted_id,
   output logic                   rsp_in_use,

   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [31:0]            csr_data
);

   localparam int ADDR_W = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
   localparam int BIT_W  = $clog2(WORD_BITS);
   localparam int CAP    = MAP_WORDS * WORD_BITS;
   localparam int SPAN_W = $clog2(CAP + 1);
   localparam int OFF_W  = $clog2(CAP);
   localparam int CMP_W  = SPAN_W + 1;
   localparam int SHIFT  = OFF_W + BIT_W;
   localparam longint RECIP = ((64'd1 << SHIFT) + WORD_BITS - 1) / WORD_BITS;
   localparam int PROD_W = OFF_W + SHIFT + 1;

   state_type               state_ff, state_in;
   logic [ADDR_W-1:0]       clr_ff, clr_in;
   logic [31:0]             base_ff, limit_ff;
   logic [MAP_WORDS-1:0]    full_ff;

   command_type             cmd_ff, cmd_in;
   logic [31:0]             id_ff, id_in;
   logic [OFF_W-1:0]        off_ff, off_in;
   logic                    oor_ff, oor_in;
   logic [SPAN_W-1:0]       span_ff, span_in;
   logic                    in_range_ff, in_range_in;
   logic [ADDR_W-1:0]       word_ff, word_in;
   logic [BIT_W-1:0]        bit_ff, bit_in;
   logic [OFF_W-1:0]        first_ff, first_in;
   logic                    found_ff, found_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   status_type              rsp_status_ff, rsp_status_in;
   logic [31:0]             rsp_granted_id_ff, rsp_granted_id_in;
   logic                    rsp_in_use_ff, rsp_in_use_in;

   logic                    rd_en, wr_en;
   logic [ADDR_W-1:0]       rd_addr, wr_addr;
   logic [WORD_BITS-1:0]    rd_data, wr_data;

   logic [ADDR_W-1:0]       word_idx;
   logic                    word_found;
   logic [BIT_W-1:0]        bit_idx;
   logic                    bit_found;

   logic                    rsp_free;
   logic                    load_rsp;
   logic [32:0]             off_full;
   logic [32:0]             diff_full;
   logic [PROD_W-1:0]       prod;
   logic [OFF_W-1:0]        rem;
   logic                    cur_bit;
   logic [WORD_BITS-1:0]    bit_mask;
   logic [OFF_W:0]          off_any;
   logic                    any_ok;

   bia_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (MAP_WORDS)
   ) u_bia_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   bia_ffs #(
      .WIDTH (MAP_WORDS)
   ) u_word_ffs (
      .vec   (~full_ff),
      .idx   (word_idx),
      .found (word_found)
   );

   bia_ffs #(
      .WIDTH (WORD_BITS)
   ) u_bit_ffs (
      .vec   (~rd_data),
      .idx   (bit_idx),
      .found (bit_found)
   );

   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_granted_id = rsp_granted_id_ff;
   assign rsp_in_use     = rsp_in_use_ff;

   // window, word and bit arithmetic
   always_comb begin
      off_full  = {1'b0, req_id} - {1'b0, base_ff};
      diff_full = {1'b0, limit_ff} - {1'b0, base_ff};
      if (limit_ff <= base_ff) begin
         span_in = '0;
      end else if (diff_full > 33'(CAP)) begin
         span_in = SPAN_W'(CAP);
      end else begin
         span_in = diff_full[SPAN_W-1:0];
      end
      prod     = PROD_W'(off_ff) * PROD_W'(RECIP);
      rem      = off_ff - OFF_W'(word_ff * WORD_BITS);
      cur_bit  = rd_data[bit_ff];
      bit_mask = WORD_BITS'(1) << bit_ff;
      off_any  = {1'b0, first_ff} + (OFF_W + 1)'(bit_ff);
      any_ok   = found_ff && (CMP_W'(off_any) < CMP_W'(span_ff));
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: begin
            if (clr_ff == ADDR_W'(MAP_WORDS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               state_in = (command_type'(req_command) == CMD_ANY) ? S_SCAN : S_DIV;
            end
         end
         S_DIV:    state_in = S_READ;
         S_READ:   state_in = S_MODIFY;
         S_MODIFY: begin
            if (rsp_free) begin
               state_in = S_IDLE;
            end
         end
         S_SCAN:   state_in = S_AREAD;
         S_AREAD:  state_in = S_AFIND;
         S_AFIND:  state_in = S_AGRANT;
         S_AGRANT: begin
            if (rsp_free) begin
               state_in = S_IDLE;
            end
         end
         default:  state_in = S_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      clr_in            = clr_ff;
      cmd_in            = cmd_ff;
      id_in             = id_ff;
      off_in            = off_ff;
      oor_in            = oor_ff;
      in_range_in       = in_range_ff;
      word_in           = word_ff;
      bit_in            = bit_ff;
      first_in          = first_ff;
      found_in          = found_ff;
      rd_en             = 1'b0;
      rd_addr           = word_ff;
      wr_en             = 1'b0;
      wr_addr           = word_ff;
      wr_data           = rd_data;
      load_rsp          = 1'b0;
      rsp_status_in     = rsp_status_ff;
      rsp_granted_id_in = rsp_granted_id_ff;
      rsp_in_use_in     = rsp_in_use_ff;

      case (state_ff)
         S_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = '0;
            clr_in  = clr_ff + ADDR_W'(1);
         end
         S_IDLE: begin
            cmd_in  = command_type'(req_command);
            id_in   = req_id;
            off_in  = off_full[OFF_W-1:0];
            oor_in  = |off_full[32:OFF_W];
         end
         S_DIV: begin
            word_in     = prod[SHIFT +: ADDR_W];
            in_range_in = !oor_ff && (SPAN_W'(off_ff) < span_ff);
         end
         S_READ: begin
            rd_en  = 1'b1;
            bit_in = rem[BIT_W-1:0];
         end
         S_MODIFY: begin
            load_rsp          = rsp_free;
            rsp_granted_id_in = id_ff;
            if (!in_range_ff) begin
               rsp_status_in = STAT_RANGE;
               rsp_in_use_in = 1'b0;
            end else begin
               case (cmd_ff)
                  CMD_ALLOC: begin
                     rsp_in_use_in = 1'b1;
                     if (cur_bit) begin
                        rsp_status_in = STAT_REFUSED;
                     end else begin
                        rsp_status_in = STAT_OK;
                        wr_en         = rsp_free;
                        wr_data       = rd_data | bit_mask;
                     end
                  end
                  CMD_FREE: begin
                     rsp_in_use_in = 1'b0;
                     if (!cur_bit) begin
                        rsp_status_in = STAT_REFUSED;
                     end else begin
                        rsp_status_in = STAT_OK;
                        wr_en         = rsp_free;
                        wr_data       = rd_data & ~bit_mask;
                     end
                  end
                  CMD_QUERY: begin
                     rsp_status_in = STAT_OK;
                     rsp_in_use_in = cur_bit;
                  end
                  default: begin
                     rsp_status_in = STAT_OK;
                     rsp_in_use_in = cur_bit;
                  end
               endcase
            end
         end
         S_SCAN: begin
            word_in  = word_idx;
            found_in = word_found;
         end
         S_AREAD: begin
            rd_en    = 1'b1;
            first_in = OFF_W'(word_ff * WORD_BITS);
         end
         S_AFIND: begin
            bit_in   = bit_idx;
            found_in = found_ff && bit_found;
         end
         S_AGRANT: begin
            load_rsp = rsp_free;
            if (any_ok) begin
               rsp_status_in     = STAT_OK;
               rsp_granted_id_in = base_ff + 32'(off_any);
               rsp_in_use_in     = 1'b1;
               wr_en             = rsp_free;
               wr_data           = rd_data | bit_mask;
            end else begin
               rsp_status_in     = STAT_FULL;
               rsp_granted_id_in = id_ff;
               rsp_in_use_in     = 1'b0;
            end
         end
         default: begin
            clr_in = clr_ff;
         end
      endcase

      rsp_valid_in = load_rsp || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         base_ff      <= ID_BASE_RESET;
         limit_ff     <= ID_LIMIT_RESET;
         full_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            if (csr_index == REG_ID_BASE) begin
               base_ff <= csr_data;
            end else if (csr_index == REG_ID_LIMIT) begin
               limit_ff <= csr_data;
            end
         end
         if (wr_en) begin
            full_ff[wr_addr] <= &wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      id_ff       <= id_in;
      off_ff      <= off_in;
      oor_ff      <= oor_in;
      in_range_ff <= in_range_in;
      word_ff     <= word_in;
      bit_ff      <= bit_in;
      first_ff    <= first_in;
      found_ff    <= found_in;
      if (state_ff == S_IDLE) begin
         span_ff <= span_in;
      end
      if (load_rsp) begin
         rsp_status_ff     <= rsp_status_in;
         rsp_granted_id_ff <= rsp_granted_id_in;
         rsp_in_use_ff     <= rsp_in_use_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/bia_checker.sv -----
`default_nettype none

module bia_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [1:0]  rsp_status,
   input logic [31:0] rsp_granted_id,
   input logic        rsp_in_use
);

   // clearing pass holds off requests straight after reset
   a_stall_after_reset: assert property (@(posedge clock)
      reset |=> req_stall)
      else $error("request taken during clearing pass");

   // one request in flight at a time
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("second request taken while one is in flight");

   // a new result only appears at the end of a request's processing
   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result appeared without a request in progress");

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_status) &&
         $stable(rsp_granted_id) && $stable(rsp_in_use)))
      else $error("stalled result changed");

endmodule

bind bitmap_id_allocator bia_checker u_bia_checker (.*);

`default_nettype wire
